@@ sv/fcsg_pkg.sv @@
// Shared types, constants and lookup tables of the five-channel sound generator.
package fcsg_pkg;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_WRITE   = 3'd1,
    OP_READ    = 3'd2,
    OP_DELIVER = 3'd3,
    OP_SRESET  = 3'd4
  } op_e;

  localparam logic [4:0] REG_TRI_LIN   = 5'h08;
  localparam logic [4:0] REG_TRI_LO    = 5'h0A;
  localparam logic [4:0] REG_TRI_HI    = 5'h0B;
  localparam logic [4:0] REG_NOISE_CTL = 5'h0C;
  localparam logic [4:0] REG_NOISE_PER = 5'h0E;
  localparam logic [4:0] REG_NOISE_LEN = 5'h0F;
  localparam logic [4:0] REG_DMC_CTL   = 5'h10;
  localparam logic [4:0] REG_DMC_LVL   = 5'h11;
  localparam logic [4:0] REG_DMC_ADDR  = 5'h12;
  localparam logic [4:0] REG_DMC_LEN   = 5'h13;
  localparam logic [4:0] REG_STATUS    = 5'h15;
  localparam logic [4:0] REG_FRAME     = 5'h17;

  localparam logic [15:0] STEP_A = 16'd7457;
  localparam logic [15:0] STEP_B = 16'd14913;
  localparam logic [15:0] STEP_C = 16'd22371;
  localparam logic [15:0] STEP_D = 16'd29829;
  localparam logic [15:0] STEP_E = 16'd37281;

  localparam int unsigned IN_W  = 24;
  localparam int unsigned OUT_W = 40;

  function automatic logic [7:0] len_lookup(input logic [4:0] i);
    logic [7:0] r;
    case (i)
      5'd0: r = 8'd10;   5'd1: r = 8'd254;  5'd2: r = 8'd20;  5'd3: r = 8'd2;
      5'd4: r = 8'd40;   5'd5: r = 8'd4;    5'd6: r = 8'd80;  5'd7: r = 8'd6;
      5'd8: r = 8'd160;  5'd9: r = 8'd8;    5'd10: r = 8'd60; 5'd11: r = 8'd10;
      5'd12: r = 8'd14;  5'd13: r = 8'd12;  5'd14: r = 8'd26; 5'd15: r = 8'd14;
      5'd16: r = 8'd12;  5'd17: r = 8'd16;  5'd18: r = 8'd24; 5'd19: r = 8'd18;
      5'd20: r = 8'd48;  5'd21: r = 8'd20;  5'd22: r = 8'd96; 5'd23: r = 8'd22;
      5'd24: r = 8'd192; 5'd25: r = 8'd24;  5'd26: r = 8'd72; 5'd27: r = 8'd26;
      5'd28: r = 8'd16;  5'd29: r = 8'd28;  5'd30: r = 8'd32; default: r = 8'd30;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] duty_lookup(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0: r = 8'h02;
      2'd1: r = 8'h06;
      2'd2: r = 8'h1E;
      default: r = 8'hF9;
    endcase
    return r;
  endfunction

  function automatic logic [11:0] noise_lookup(input logic [3:0] i);
    logic [11:0] r;
    case (i)
      4'd0: r = 12'd4;    4'd1: r = 12'd8;    4'd2: r = 12'd16;   4'd3: r = 12'd32;
      4'd4: r = 12'd64;   4'd5: r = 12'd96;   4'd6: r = 12'd128;  4'd7: r = 12'd160;
      4'd8: r = 12'd202;  4'd9: r = 12'd254;  4'd10: r = 12'd380; 4'd11: r = 12'd508;
      4'd12: r = 12'd762; 4'd13: r = 12'd1016; 4'd14: r = 12'd2034;
      default: r = 12'd4068;
    endcase
    return r;
  endfunction

  // Rate table values, already reduced by one.
  function automatic logic [8:0] rate_lookup(input logic [3:0] i);
    logic [8:0] r;
    case (i)
      4'd0: r = 9'd427;  4'd1: r = 9'd379;  4'd2: r = 9'd339;  4'd3: r = 9'd319;
      4'd4: r = 9'd285;  4'd5: r = 9'd253;  4'd6: r = 9'd225;  4'd7: r = 9'd213;
      4'd8: r = 9'd189;  4'd9: r = 9'd159;  4'd10: r = 9'd141; 4'd11: r = 9'd127;
      4'd12: r = 9'd105; 4'd13: r = 9'd83;  4'd14: r = 9'd71;  default: r = 9'd53;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic [7:0]  read_data;
    logic [4:0]  pulse_level;
    logic [7:0]  tnd_level;
    logic        irq;
    logic        fetch_request;
    logic [15:0] fetch_address;
  } result_t;

endpackage

@@ sv/fcsg_core.sv @@
// Sound generator state and the single-pass update of one input word.
module fcsg_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [2:0]              operation_i,
  input  logic [4:0]              reg_addr_i,
  input  logic [7:0]              write_data_i,
  input  logic [7:0]              fetch_data_i,
  output fcsg_pkg::result_t       result_o
);
  import fcsg_pkg::*;

  logic [15:0] fs_q, fs_d;
  logic mode5_q, mode5_d, inhibit_q, inhibit_d, firq_q, firq_d, restart_q, restart_d;
  logic [4:0] en_q, en_d;
  logic par_q, par_d;

  logic [10:0] pper_q [2], pper_d [2];
  logic [10:0] pcnt_q [2], pcnt_d [2];
  logic [2:0]  pduty_q [2], pduty_d [2];
  logic [7:0]  pctl_q [2], pctl_d [2];
  logic [3:0]  pecnt_q [2], pecnt_d [2];
  logic [3:0]  pelvl_q [2], pelvl_d [2];
  logic [7:0]  psw_q [2], psw_d [2];
  logic [3:0]  pscnt_q [2], pscnt_d [2];
  logic [1:0]  psrl_q, psrl_d;
  logic [7:0]  plen_q [2], plen_d [2];

  logic [10:0] tper_q, tper_d, tcnt_q, tcnt_d;
  logic [4:0]  tstep_q, tstep_d;
  logic [6:0]  tlin_q, tlin_d, tlrl_q, tlrl_d;
  logic [7:0]  tlen_q, tlen_d;
  logic        thalt_q, thalt_d, trfl_q, trfl_d;

  logic [14:0] lfsr_q, lfsr_d;
  logic [11:0] nper_q, nper_d, ncnt_q, ncnt_d;
  logic        nmode_q, nmode_d;
  logic [5:0]  nctl_q, nctl_d;
  logic [3:0]  necnt_q, necnt_d, nelvl_q, nelvl_d;
  logic [7:0]  nlen_q, nlen_d;

  logic [8:0]  drate_q, drate_d, drcnt_q, drcnt_d;
  logic [6:0]  dlvl_q, dlvl_d;
  logic [15:0] dsa_q, dsa_d, dca_q, dca_d;
  logic [11:0] dsl_q, dsl_d, dbl_q, dbl_d;
  logic [7:0]  dbuf_q, dbuf_d, dbits_q, dbits_d;
  logic [3:0]  dbleft_q, dbleft_d;
  logic dempty_q, dempty_d, dsil_q, dsil_d, dloop_q, dloop_d, dien_q, dien_d;
  logic dirq_q, dirq_d, dlat_q, dlat_d, dpend_q, dpend_d;

  result_t res_q, res_d;
  assign result_o = res_q;

  // Sweep target of a pulse channel; channel 0 subtracts one more.
  function automatic logic [11:0] sweep_target(input logic [10:0] p, input logic [7:0] sw,
                                               input logic ch1, output logic mute);
    logic [10:0] c;
    logic [11:0] sub, t;
    c = p >> sw[2:0];
    if (sw[3]) begin
      sub = {1'b0, c} + {11'd0, ~ch1};
      t = ({1'b0, p} >= sub) ? ({1'b0, p} - sub) : 12'd0;
    end else begin
      t = {1'b0, p} + {1'b0, c};
    end
    mute = (p < 11'd8) || t[11];
    return t;
  endfunction

  function automatic logic [7:0] status(input logic [7:0] l0, input logic [7:0] l1,
                                        input logic [7:0] tl, input logic [7:0] nl,
                                        input logic [11:0] bl, input logic fi,
                                        input logic di);
    return {di, fi, 1'b0, bl != 12'd0, nl != 8'd0, tl != 8'd0, l1 != 8'd0, l0 != 8'd0};
  endfunction

  always_comb begin
    logic q, h, mute, fb, req;
    logic [11:0] tgt;
    logic [15:0] raddr;
    logic [7:0] rd, lv;
    logic [4:0] pl;
    logic [7:0] tnd;
    logic [3:0] vol, tv;
    logic [7:0] dm;
    fs_d = fs_q; mode5_d = mode5_q; inhibit_d = inhibit_q; firq_d = firq_q;
    restart_d = restart_q; en_d = en_q; par_d = par_q;
    pper_d = pper_q; pcnt_d = pcnt_q; pduty_d = pduty_q; pctl_d = pctl_q;
    pecnt_d = pecnt_q; pelvl_d = pelvl_q; psw_d = psw_q; pscnt_d = pscnt_q;
    psrl_d = psrl_q; plen_d = plen_q;
    tper_d = tper_q; tcnt_d = tcnt_q; tstep_d = tstep_q; tlin_d = tlin_q;
    tlrl_d = tlrl_q; tlen_d = tlen_q; thalt_d = thalt_q; trfl_d = trfl_q;
    lfsr_d = lfsr_q; nper_d = nper_q; ncnt_d = ncnt_q; nmode_d = nmode_q;
    nctl_d = nctl_q; necnt_d = necnt_q; nelvl_d = nelvl_q; nlen_d = nlen_q;
    drate_d = drate_q; drcnt_d = drcnt_q; dlvl_d = dlvl_q; dsa_d = dsa_q;
    dca_d = dca_q; dsl_d = dsl_q; dbl_d = dbl_q; dbuf_d = dbuf_q; dbits_d = dbits_q;
    dbleft_d = dbleft_q; dempty_d = dempty_q; dsil_d = dsil_q; dloop_d = dloop_q;
    dien_d = dien_q; dirq_d = dirq_q; dlat_d = dlat_q; dpend_d = dpend_q;
    q = 1'b0; h = 1'b0; req = 1'b0; raddr = 16'd0; mute = 1'b0;
    rd = status(plen_q[0], plen_q[1], tlen_q, nlen_q, dbl_q, firq_q, dirq_q);

    case (operation_i)
      OP_TICK: begin
        if (restart_q) begin
          restart_d = 1'b0;
          q = mode5_q; h = mode5_q;
          fs_d = 16'd0;
        end else begin
          case (fs_q)
            STEP_A: begin q = 1'b1; fs_d = fs_q + 16'd1; end
            STEP_B: begin q = 1'b1; h = 1'b1; fs_d = fs_q + 16'd1; end
            STEP_C: begin q = 1'b1; fs_d = fs_q + 16'd1; end
            STEP_D: begin
              if (mode5_q) fs_d = fs_q + 16'd1;
              else begin
                q = 1'b1; h = 1'b1; fs_d = 16'd0;
                if (!inhibit_q) firq_d = 1'b1;
              end
            end
            STEP_E: begin q = 1'b1; h = 1'b1; fs_d = 16'd0; end
            default: fs_d = fs_q + 16'd1;
          endcase
        end
        if (q) begin
          for (int i = 0; i < 2; i++) begin
            if (pecnt_q[i] != 4'd0) pecnt_d[i] = pecnt_q[i] - 4'd1;
            else begin
              pecnt_d[i] = pctl_q[i][3:0];
              if (pelvl_q[i] == 4'd0) begin
                if (pctl_q[i][5]) pelvl_d[i] = 4'd15;
              end else pelvl_d[i] = pelvl_q[i] - 4'd1;
            end
          end
          if (necnt_q != 4'd0) necnt_d = necnt_q - 4'd1;
          else begin
            necnt_d = nctl_q[3:0];
            if (nelvl_q == 4'd0) begin
              if (nctl_q[5]) nelvl_d = 4'd15;
            end else nelvl_d = nelvl_q - 4'd1;
          end
          if (trfl_q) tlin_d = tlrl_q;
          else if (tlin_q != 7'd0) tlin_d = tlin_q - 7'd1;
          if (!thalt_q) trfl_d = 1'b0;
        end
        if (h) begin
          for (int i = 0; i < 2; i++) begin
            logic [3:0] sc;
            tgt = sweep_target(pper_q[i], psw_q[i], i[0], mute);
            sc = psrl_q[i] ? 4'd0 : pscnt_q[i];
            psrl_d[i] = 1'b0;
            if (sc != 4'd0) pscnt_d[i] = sc - 4'd1;
            else begin
              pscnt_d[i] = {1'b0, psw_q[i][6:4]} + 4'd1;
              if (psw_q[i][7] && (psw_q[i][2:0] != 3'd0) && !mute)
                pper_d[i] = tgt[10:0];
            end
            if (plen_q[i] != 8'd0 && !pctl_q[i][5]) plen_d[i] = plen_q[i] - 8'd1;
          end
          if (!thalt_q && tlen_q != 8'd0) tlen_d = tlen_q - 8'd1;
          if (nlen_q != 8'd0 && !nctl_q[5]) nlen_d = nlen_q - 8'd1;
        end
        if (par_q) begin
          for (int i = 0; i < 2; i++) begin
            if (pcnt_q[i] != 11'd0) pcnt_d[i] = pcnt_q[i] - 11'd1;
            else begin
              pcnt_d[i] = pper_d[i];
              pduty_d[i] = pduty_q[i] + 3'd1;
            end
          end
          if (ncnt_q != 12'd0) ncnt_d = ncnt_q - 12'd1;
          else begin
            ncnt_d = nper_q;
            fb = lfsr_q[0] ^ (nmode_q ? lfsr_q[6] : lfsr_q[1]);
            lfsr_d = {fb, lfsr_q[14:1]};
          end
        end
        // Delta-modulation fetch and output unit.
        if (en_q[4] && dempty_q && !dpend_q) begin
          if (dbl_q != 12'd0) begin
            req = 1'b1; raddr = dca_q; dpend_d = 1'b1;
            dbl_d = dbl_q - 12'd1;
            dca_d = (dca_q == 16'hFFFF) ? 16'h8000 : dca_q + 16'd1;
            dlat_d = 1'b0;
          end
          if (dbl_d == 12'd0) begin
            if (dloop_q) begin
              dca_d = dsa_q; dbl_d = dsl_q;
            end else if (dien_q && !dlat_d) begin
              dirq_d = 1'b1; dlat_d = 1'b1;
            end
          end
        end
        if (drcnt_q != 9'd0) drcnt_d = drcnt_q - 9'd1;
        else begin
          drcnt_d = drate_q;
          dbleft_d = dbleft_q;
          if (dbleft_q != 4'd0) begin
            if (!dsil_q) begin
              if (dbits_q[0]) dlvl_d = (dlvl_q > 7'd125) ? 7'd127 : dlvl_q + 7'd2;
              else if (dlvl_q > 7'd1) dlvl_d = dlvl_q - 7'd2;
              dbits_d = dbits_q >> 1;
            end
            dbleft_d = dbleft_q - 4'd1;
          end
          if (dbleft_d == 4'd0) begin
            if (dempty_q) dsil_d = 1'b1;
            else begin
              dbits_d = dbuf_q; dempty_d = 1'b1; dsil_d = 1'b0;
            end
            dbleft_d = 4'd8;
          end
        end
        if (tcnt_q != 11'd0) tcnt_d = tcnt_q - 11'd1;
        else begin
          tcnt_d = tper_q;
          if (tlen_d != 8'd0 && tlin_d != 7'd0) tstep_d = tstep_q + 5'd1;
        end
        par_d = ~par_q;
      end
      OP_WRITE: begin
        if (reg_addr_i < 5'd8) begin
          case (reg_addr_i[1:0])
            2'd0: begin
              pctl_d[reg_addr_i[2]] = write_data_i;
              pecnt_d[reg_addr_i[2]] = write_data_i[3:0];
              pelvl_d[reg_addr_i[2]] = 4'd15;
            end
            2'd1: begin
              psw_d[reg_addr_i[2]] = write_data_i;
              pscnt_d[reg_addr_i[2]] = {1'b0, write_data_i[6:4]} + 4'd1;
              psrl_d[reg_addr_i[2]] = 1'b1;
            end
            2'd2: pper_d[reg_addr_i[2]] = {pper_q[reg_addr_i[2]][10:8], write_data_i};
            default: begin
              pper_d[reg_addr_i[2]] = {write_data_i[2:0], pper_q[reg_addr_i[2]][7:0]};
              if (en_q[reg_addr_i[2]]) plen_d[reg_addr_i[2]] = len_lookup(write_data_i[7:3]);
              pelvl_d[reg_addr_i[2]] = 4'd15;
            end
          endcase
        end else begin
          case (reg_addr_i)
            REG_TRI_LIN: begin tlrl_d = write_data_i[6:0]; thalt_d = write_data_i[7]; end
            REG_TRI_LO: tper_d = {tper_q[10:8], write_data_i};
            REG_TRI_HI: begin
              tper_d = {write_data_i[2:0], tper_q[7:0]};
              trfl_d = 1'b1;
              if (en_q[2]) tlen_d = len_lookup(write_data_i[7:3]);
            end
            REG_NOISE_CTL: nctl_d = write_data_i[5:0];
            REG_NOISE_PER: begin
              nper_d = noise_lookup(write_data_i[3:0]); nmode_d = write_data_i[7];
            end
            REG_NOISE_LEN: begin
              if (en_q[3]) nlen_d = len_lookup(write_data_i[7:3]);
              nelvl_d = 4'd15;
            end
            REG_DMC_CTL: begin
              dloop_d = write_data_i[6]; dien_d = write_data_i[7];
              if (!write_data_i[7]) dirq_d = 1'b0;
              drate_d = rate_lookup(write_data_i[3:0]);
            end
            REG_DMC_LVL: dlvl_d = write_data_i[6:0];
            REG_DMC_ADDR: dsa_d = {2'b11, write_data_i, 6'd0};
            REG_DMC_LEN: dsl_d = {write_data_i, 4'd1};
            REG_STATUS: begin
              en_d = write_data_i[4:0];
              if (write_data_i[4] && dbl_q == 12'd0) begin
                dbl_d = dsl_q; dca_d = dsa_q;
              end else if (!write_data_i[4]) dbl_d = 12'd0;
              dirq_d = 1'b0;
              if (!write_data_i[0]) plen_d[0] = 8'd0;
              if (!write_data_i[1]) plen_d[1] = 8'd0;
              if (!write_data_i[2]) tlen_d = 8'd0;
              if (!write_data_i[3]) nlen_d = 8'd0;
            end
            REG_FRAME: begin
              inhibit_d = write_data_i[6]; mode5_d = write_data_i[7];
              if (write_data_i[6]) firq_d = 1'b0;
              restart_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      OP_READ: firq_d = 1'b0;
      OP_DELIVER: begin
        if (dpend_q) begin
          dbuf_d = fetch_data_i; dempty_d = 1'b0; dpend_d = 1'b0;
        end
      end
      OP_SRESET: begin
        en_d = 5'd0; dbl_d = 12'd0; dirq_d = 1'b0;
        plen_d[0] = 8'd0; plen_d[1] = 8'd0; tlen_d = 8'd0; nlen_d = 8'd0;
        tstep_d = 5'd0; dlvl_d = {6'd0, dlvl_q[0]}; firq_d = 1'b0;
      end
      default: ;
    endcase

    if (operation_i != OP_READ)
      rd = status(plen_d[0], plen_d[1], tlen_d, nlen_d, dbl_d, firq_d, dirq_d);

    pl = 5'd0;
    for (int i = 0; i < 2; i++) begin
      tgt = sweep_target(pper_d[i], psw_d[i], i[0], mute);
      vol = pctl_d[i][4] ? pctl_d[i][3:0] : pelvl_d[i];
      dm = duty_lookup(pctl_d[i][7:6]);
      if (en_d[i] && plen_d[i] != 8'd0 && !mute && dm[pduty_d[i]])
        pl = pl + {1'b0, vol};
    end
    tnd = {1'b0, dlvl_d};
    if (en_d[2] && tper_d > 11'd1) begin
      tv = tstep_d[4] ? tstep_d[3:0] : ~tstep_d[3:0];
      lv = {4'd0, tv};
      tnd = tnd + lv + lv + lv;
    end
    if (en_d[3] && !lfsr_d[0] && nlen_d != 8'd0) begin
      vol = nctl_d[4] ? nctl_d[3:0] : nelvl_d;
      tnd = tnd + {3'd0, vol, 1'b0};
    end
    res_d.read_data = rd;
    res_d.pulse_level = pl;
    res_d.tnd_level = tnd;
    res_d.irq = firq_d | dirq_d;
    res_d.fetch_request = req;
    res_d.fetch_address = raddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= '0; mode5_q <= 1'b0; inhibit_q <= 1'b0; firq_q <= 1'b0; restart_q <= 1'b1;
      en_q <= '0; par_q <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        pper_q[i] <= '0; pcnt_q[i] <= '0; pduty_q[i] <= '0; pctl_q[i] <= '0;
        pecnt_q[i] <= '0; pelvl_q[i] <= '0; psw_q[i] <= '0; pscnt_q[i] <= '0;
        plen_q[i] <= '0;
      end
      psrl_q <= '0;
      tper_q <= '0; tcnt_q <= '0; tstep_q <= '0; tlin_q <= '0; tlrl_q <= '0;
      tlen_q <= '0; thalt_q <= 1'b1; trfl_q <= 1'b0;
      lfsr_q <= 15'd1; nper_q <= '0; ncnt_q <= '0; nmode_q <= 1'b0; nctl_q <= '0;
      necnt_q <= '0; nelvl_q <= '0; nlen_q <= '0;
      drate_q <= '0; drcnt_q <= '0; dlvl_q <= '0; dsa_q <= '0; dca_q <= '0;
      dsl_q <= '0; dbl_q <= '0; dbuf_q <= '0; dbits_q <= '0; dbleft_q <= '0;
      dempty_q <= 1'b1; dsil_q <= 1'b1; dloop_q <= 1'b0; dien_q <= 1'b0;
      dirq_q <= 1'b0; dlat_q <= 1'b0; dpend_q <= 1'b0;
      res_q <= '0;
    end else if (step_i) begin
      fs_q <= fs_d; mode5_q <= mode5_d; inhibit_q <= inhibit_d; firq_q <= firq_d;
      restart_q <= restart_d; en_q <= en_d; par_q <= par_d;
      pper_q <= pper_d; pcnt_q <= pcnt_d; pduty_q <= pduty_d; pctl_q <= pctl_d;
      pecnt_q <= pecnt_d; pelvl_q <= pelvl_d; psw_q <= psw_d; pscnt_q <= pscnt_d;
      plen_q <= plen_d; psrl_q <= psrl_d;
      tper_q <= tper_d; tcnt_q <= tcnt_d; tstep_q <= tstep_d; tlin_q <= tlin_d;
      tlrl_q <= tlrl_d; tlen_q <= tlen_d; thalt_q <= thalt_d; trfl_q <= trfl_d;
      lfsr_q <= lfsr_d; nper_q <= nper_d; ncnt_q <= ncnt_d; nmode_q <= nmode_d;
      nctl_q <= nctl_d; necnt_q <= necnt_d; nelvl_q <= nelvl_d; nlen_q <= nlen_d;
      drate_q <= drate_d; drcnt_q <= drcnt_d; dlvl_q <= dlvl_d; dsa_q <= dsa_d;
      dca_q <= dca_d; dsl_q <= dsl_d; dbl_q <= dbl_d; dbuf_q <= dbuf_d;
      dbits_q <= dbits_d; dbleft_q <= dbleft_d; dempty_q <= dempty_d; dsil_q <= dsil_d;
      dloop_q <= dloop_d; dien_q <= dien_d; dirq_q <= dirq_d; dlat_q <= dlat_d;
      dpend_q <= dpend_d;
      res_q <= res_d;
    end
  end

endmodule

@@ sv/five_channel_sound_generator.sv @@
// Top level of the five-channel sound generator with its stream handshake.
// Each input word (tick, register write, status read, sample byte delivery or
// soft reset) is accepted and yields exactly one registered result word; with
// the output taken every cycle the block sustains one word per
// clock. The whole channel and frame-sequencer update is a single registered
// pass, and the result register is the only stage: a word is accepted whenever
// that register is empty or being drained in the same cycle. A fetch request
// in a result must be answered by a later delivery word carrying the byte.
module five_channel_sound_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] operation, [7:3] reg_addr, [15:8] write_data, [23:16] fetch_data
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] read_data, [12:8] pulse_level, [20:13] tnd_level, [21] irq,
  // [22] fetch_request, [38:23] fetch_address, [39] fetch_request (copy)
  output logic [39:0] m_axis_tdata
);
  import fcsg_pkg::*;

  logic    valid_q;
  logic    step;
  result_t res;

  assign s_axis_tready = !valid_q || m_axis_tready;
  assign step = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  fcsg_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .operation_i  (s_axis_tdata[2:0]),
    .reg_addr_i   (s_axis_tdata[7:3]),
    .write_data_i (s_axis_tdata[15:8]),
    .fetch_data_i (s_axis_tdata[23:16]),
    .result_o     (res)
  );

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata = {res.fetch_request, res.fetch_address, res.fetch_request,
                         res.irq, res.tnd_level, res.pulse_level, res.read_data};

endmodule
